>>> rtl/core/ssd_pkg.sv
// Shared types, codes and constants for the sparse squared distance block.
package ssd_pkg;

  // Operation codes carried in the input tuser field.
  localparam logic [1:0] OP_LOAD_A  = 2'd0;
  localparam logic [1:0] OP_LOAD_B  = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  // Default sizing handed to the top level.
  localparam int DEF_MAX_ENTRIES = 256;
  localparam int DEF_INDEX_BITS  = 16;

  // Fixed field widths.
  localparam int OP_W    = 2;
  localparam int IDX_IN_W = 16;
  localparam int VALUE_W = 24;
  localparam int DIFF_W  = VALUE_W + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int DIST_W  = 58;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 64;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHOOSE,
    ST_WAIT,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic step;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_done;
    logic out_free;
  } status_t;

endpackage

>>> rtl/core/ssd_ctrl.sv
// Controller state machine: request handshake and merge-walk sequencing.
module ssd_ctrl
  import ssd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic [OP_W-1:0]  op,
  input  status_t          status,
  output logic             s_tready,
  output cmd_t             cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Requests are taken only in idle; a compute request also needs a free output.
  assign s_tready = (state == ST_IDLE) && ((op != OP_COMPUTE) || status.out_free);
  assign accept   = s_tvalid && s_tready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (op == OP_COMPUTE)) begin
          state_next = ST_CHOOSE;
        end
      end
      ST_CHOOSE: begin
        if (status.walk_done) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT:   state_next = ST_CHOOSE;
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.wr_a = accept && (op == OP_LOAD_A);
        cmd.wr_b = accept && (op == OP_LOAD_B);
      end
      ST_CHOOSE: cmd.step   = !status.walk_done;
      ST_FINISH: cmd.finish = 1'b1;
      default:   cmd = '0;
    endcase
  end

  // A step is never issued once both stores are used up.
  a_step_live: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !status.walk_done)
    else $error("step issued after walk finished");

  // Every walk step is followed by the wait state for the store read.
  a_step_wait: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> (state == ST_WAIT))
    else $error("step not followed by wait");

  // A compute request leads straight into the walk.
  a_start: assert property (@(posedge clk) disable iff (rst)
    (accept && (op == OP_COMPUTE)) |=> (state == ST_CHOOSE))
    else $error("compute request did not start the walk");

endmodule

>>> rtl/core/ssd_datapath.sv
// Datapath: entry stores, merge-walk pointers, squarer, accumulator, output register.
module ssd_datapath
  import ssd_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int INDEX_BITS  = DEF_INDEX_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  input  logic [IDX_IN_W-1:0]   entry_index,
  input  logic signed [VALUE_W-1:0] entry_value,
  input  logic                  m_tready,
  output status_t               status,
  output logic                  m_tvalid,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tuser
);

  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int EW  = INDEX_BITS + VALUE_W;
  localparam logic [CW-1:0] FULL = CW'(MAX_ENTRIES);

  // Entry stores: index in the high bits, value in the low bits.
  logic [EW-1:0] mem_a [MAX_ENTRIES];
  logic [EW-1:0] mem_b [MAX_ENTRIES];
  logic [EW-1:0] rd_a;
  logic [EW-1:0] rd_b;

  logic [CW-1:0] a_count;
  logic [CW-1:0] b_count;
  logic [CW-1:0] ptr_a;
  logic [CW-1:0] ptr_b;
  logic          overflow_seen;

  logic [INDEX_BITS-1:0] idx_kept;
  logic [EW-1:0]         entry_word;

  logic                      a_live;
  logic                      b_live;
  logic                      take_a;
  logic                      take_b;
  logic [INDEX_BITS-1:0]     ia;
  logic [INDEX_BITS-1:0]     ib;
  logic signed [DIFF_W-1:0]  opa;
  logic signed [DIFF_W-1:0]  opb;
  logic signed [DIFF_W-1:0]  diff;
  logic [DIFF_W-1:0]         mag_next;

  logic [DIFF_W-1:0] mag;
  logic              mag_valid;
  logic [SQ_W-1:0]   sq;
  logic              sq_valid;
  logic [DIST_W-1:0] acc;
  logic [DIST_W:0]   sum;

  // Only the low index bits are kept.
  assign idx_kept   = INDEX_BITS'({16'b0, entry_index});
  assign entry_word = {idx_kept, entry_value};

  // Store A write port and registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_a && (a_count != FULL)) begin
      mem_a[a_count[AW-1:0]] <= entry_word;
    end
    rd_a <= mem_a[ptr_a[AW-1:0]];
  end

  // Store B write port and registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_b && (b_count != FULL)) begin
      mem_b[b_count[AW-1:0]] <= entry_word;
    end
    rd_b <= mem_b[ptr_b[AW-1:0]];
  end

  // Fill counts and the dropped-load flag.
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      a_count       <= '0;
      b_count       <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (cmd.wr_a) begin
        if (a_count != FULL) begin
          a_count <= a_count + 1'b1;
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      if (cmd.wr_b) begin
        if (b_count != FULL) begin
          b_count <= b_count + 1'b1;
        end else begin
          overflow_seen <= 1'b1;
        end
      end
    end
  end

  // Merge decision: the lower index goes first, equal indices pair up.
  assign a_live = (ptr_a < a_count);
  assign b_live = (ptr_b < b_count);
  assign ia     = rd_a[EW-1:VALUE_W];
  assign ib     = rd_b[EW-1:VALUE_W];
  assign take_a = a_live && (!b_live || (ia <= ib));
  assign take_b = b_live && (!a_live || (ib <= ia));

  assign opa      = take_a ? DIFF_W'($signed(rd_a[VALUE_W-1:0])) : '0;
  assign opb      = take_b ? DIFF_W'($signed(rd_b[VALUE_W-1:0])) : '0;
  assign diff     = opa - opb;
  assign mag_next = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

  assign status.walk_done = !a_live && !b_live;
  assign status.out_free  = !m_tvalid || m_tready;

  // Walk pointers.
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      ptr_a <= '0;
      ptr_b <= '0;
    end else if (cmd.step) begin
      if (take_a) begin
        ptr_a <= ptr_a + 1'b1;
      end
      if (take_b) begin
        ptr_b <= ptr_b + 1'b1;
      end
    end
  end

  // Magnitude, square and accumulate, one register per stage.
  always_ff @(posedge clk) begin
    mag <= mag_next;
    sq  <= mag * mag;
    if (rst) begin
      mag_valid <= 1'b0;
      sq_valid  <= 1'b0;
    end else begin
      mag_valid <= cmd.step;
      sq_valid  <= mag_valid;
    end
  end

  assign sum = {1'b0, acc} + (DIST_W + 1)'(sq);

  // Saturating accumulator.
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      acc <= '0;
    end else if (sq_valid) begin
      acc <= sum[DIST_W] ? '1 : sum[DIST_W-1:0];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (cmd.finish) begin
      m_tdata <= OUT_DATA_W'(acc);
      m_tuser <= overflow_seen;
    end
  end

  // Pointers never pass the fill counts.
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (ptr_a <= a_count) && (ptr_b <= b_count))
    else $error("walk pointer beyond fill count");

  // A result is only loaded into a free output register.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!m_tvalid || m_tready))
    else $error("result overwrote a pending result");

  // The squarer pipeline is empty when the result is taken.
  a_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!mag_valid && !sq_valid))
    else $error("result taken before accumulation finished");

  // Finishing resets both fill counts and the dropped-load flag.
  a_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> ((a_count == '0) && (b_count == '0) && !overflow_seen))
    else $error("stores not cleared after compute");

endmodule

>>> rtl/core/sparse_squared_distance.sv
// Top level of the sparse squared distance block.
//
//   Channel   Dir  Bits             Contents
//   s_tdata   in   [39:0]           entry_index [15:0], entry_value [39:16]
//   s_tuser   in   [1:0]            operation (load A, load B, compute)
//   m_tdata   out  [63:0]           distance [57:0], zero [63:58]
//   m_tuser   out  [0:0]            truncated
//
// Load requests are taken one per cycle while the sequencer is idle. A compute
// request runs the merge walk: each step decides in ST_CHOOSE and then waits in
// ST_WAIT for the registered store read, one step per index visited, up to
// a_count + b_count steps; ST_FINISH then loads the result. Reset clears the
// counts, pointers, flag and output valid; store contents are left as they are.
// A pending result stalls only compute requests; loads still enter.
module sparse_squared_distance
  import ssd_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int INDEX_BITS  = DEF_INDEX_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // entry_index [15:0], entry_value [39:16]
  input  logic [OP_W-1:0]       s_tuser,   // operation [1:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // distance [57:0], zero pad [63:58]
  output logic                  m_tuser    // truncated [0]
);

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  ssd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .op       (s_tuser),
    .status   (status),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  // Stores and arithmetic.
  ssd_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .INDEX_BITS  (INDEX_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .entry_index (s_tdata[IDX_IN_W-1:0]),
    .entry_value ($signed(s_tdata[IDX_IN_W+VALUE_W-1:IDX_IN_W])),
    .m_tready    (m_tready),
    .status      (status),
    .m_tvalid    (m_tvalid),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

endmodule

>>> tb/sparse_squared_distance_check.sv
// Checker for the sparse squared distance block: tracks both stores and scores every result.
module sparse_squared_distance_check
  import ssd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // entry_index [15:0], entry_value [39:16]
  input  logic [OP_W-1:0]       s_tuser,   // operation [1:0]
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,   // distance [57:0], zero pad [63:58]
  input  logic                  m_tuser,   // truncated [0]
  output int                    mismatches,
  output int                    awaiting,
  output int                    distances_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [DIST_W-1:0] DIST_CEILING = '1;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              truncated;
  } distance_result_t;

  // Shadow copies of the two entry stores.
  logic [IDX_IN_W-1:0]       a_index [DEF_MAX_ENTRIES];
  logic signed [VALUE_W-1:0] a_value [DEF_MAX_ENTRIES];
  logic [IDX_IN_W-1:0]       b_index [DEF_MAX_ENTRIES];
  logic signed [VALUE_W-1:0] b_value [DEF_MAX_ENTRIES];
  int                        a_len = 0;
  int                        b_len = 0;
  bit                        dropped_load = 0;

  // Distances still owed by the block, oldest first.
  distance_result_t distance_q[$];

  function automatic longint unsigned squared(input longint d);
    longint unsigned mag;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    return mag * mag;
  endfunction

  // The sum clamps at the top of the 58-bit range instead of wrapping.
  function automatic logic [DIST_W-1:0] add_clamped(input logic [DIST_W-1:0] sum,
                                                    input longint unsigned term);
    if (term > 64'(DIST_CEILING - sum)) return DIST_CEILING;
    return sum + DIST_W'(term);
  endfunction

  // Merge walk over both stores in stored order; leftovers are added squared.
  function automatic logic [DIST_W-1:0] merged_distance();
    int                i;
    int                j;
    logic [DIST_W-1:0] sum;
    i = 0;
    j = 0;
    sum = '0;
    while (i < a_len && j < b_len) begin
      if (a_index[i] == b_index[j]) begin
        sum = add_clamped(sum, squared(longint'(a_value[i]) - longint'(b_value[j])));
        i++;
        j++;
      end else if (a_index[i] < b_index[j]) begin
        sum = add_clamped(sum, squared(longint'(a_value[i])));
        i++;
      end else begin
        sum = add_clamped(sum, squared(longint'(b_value[j])));
        j++;
      end
    end
    for (; i < a_len; i++) sum = add_clamped(sum, squared(longint'(a_value[i])));
    for (; j < b_len; j++) sum = add_clamped(sum, squared(longint'(b_value[j])));
    return sum;
  endfunction

  // A load into a full store is dropped and remembered for the next result.
  task automatic store_entry(input bit to_b, input logic [IDX_IN_W-1:0] idx,
                             input logic signed [VALUE_W-1:0] val);
    if (!to_b) begin
      if (a_len >= DEF_MAX_ENTRIES) begin
        dropped_load = 1;
      end else begin
        a_index[a_len] = idx;
        a_value[a_len] = val;
        a_len++;
      end
    end else begin
      if (b_len >= DEF_MAX_ENTRIES) begin
        dropped_load = 1;
      end else begin
        b_index[b_len] = idx;
        b_value[b_len] = val;
        b_len++;
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Score results first, then fold in the request taken at the same edge.
  always @(posedge clk) begin
    distance_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        distances_seen++;
        if (distance_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing outstanding, distance %0h",
                                    m_tdata[DIST_W-1:0]));
        end else begin
          want = distance_q.pop_front();
          if (m_tdata[DIST_W-1:0] !== want.distance)
            report_mismatch($sformatf("distance %0h, predicted %0h",
                                      m_tdata[DIST_W-1:0], want.distance));
          if (m_tuser !== want.truncated)
            report_mismatch($sformatf("truncated %b, predicted %b",
                                      m_tuser, want.truncated));
        end
      end
      if (s_tvalid && s_tready) begin
        case (s_tuser)
          OP_LOAD_A: begin
            store_entry(1'b0, s_tdata[IDX_IN_W-1:0], s_tdata[IDX_IN_W +: VALUE_W]);
          end
          OP_LOAD_B: begin
            store_entry(1'b1, s_tdata[IDX_IN_W-1:0], s_tdata[IDX_IN_W +: VALUE_W]);
          end
          OP_COMPUTE: begin
            want.distance  = merged_distance();
            want.truncated = dropped_load;
            distance_q.push_back(want);
            a_len = 0;
            b_len = 0;
            dropped_load = 0;
          end
          default: begin
            // The spare operation code leaves everything untouched.
          end
        endcase
      end
    end
    awaiting <= distance_q.size();
  end

endmodule

>>> tb/sparse_squared_distance_test.sv
// Stimulus and verdict for the sparse squared distance block.
module sparse_squared_distance_test;
  import ssd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 1100;
  localparam int PHASE_REQUESTS = 175;

  bit                    clk = 0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // entry_index [15:0], entry_value [39:16]
  logic [OP_W-1:0]       s_tuser = '0;   // operation [1:0]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // distance [57:0], zero pad [63:58]
  logic                  m_tuser;        // truncated [0]

  int   mismatches;
  int   awaiting;
  int   distances_seen;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   requests_sent = 0;
  int   quiet_cycles = 0;
  logic hold_go = 1'b0;

  always #10 clk = ~clk;

  sparse_squared_distance dut (.*);

  sparse_squared_distance_check u_check (.*);

  // Output side: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go <= 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Give up when neither channel has moved for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request and return at the edge that takes it.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_IN_W-1:0] idx,
                              input logic [VALUE_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {val, idx};
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    if (op != OP_UNUSED) requests_sent++;
  endtask

  // Stop offering and let every owed distance come back.
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  // Mostly uniform values, with the range ends and sign boundary mixed in.
  function automatic logic [VALUE_W-1:0] random_value();
    case ($urandom_range(15))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return 24'h000000;
      3:       return 24'hFFFFFF;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // One pair of vectors followed by a compute; some are unsorted or left pending.
  task automatic run_sequence();
    logic [IDX_IN_W-1:0] a_list[$];
    logic [IDX_IN_W-1:0] b_list[$];
    int                  na;
    int                  nb;
    int                  span;
    int                  ai;
    int                  bi;
    na = ($urandom_range(15) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 10);
    nb = ($urandom_range(15) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 10);
    // A narrow index span makes shared and repeated indices common.
    span = $urandom_range(1) ? 65535 : $urandom_range(3, 40);
    repeat (na) a_list.push_back(IDX_IN_W'($urandom_range(span)));
    repeat (nb) begin
      if (a_list.size() != 0 && $urandom_range(1))
        b_list.push_back(a_list[$urandom_range(a_list.size() - 1)]);
      else
        b_list.push_back(IDX_IN_W'($urandom_range(span)));
    end
    if ($urandom_range(9) != 0) begin
      a_list.sort();
      b_list.sort();
    end
    ai = 0;
    bi = 0;
    while (ai < na || bi < nb) begin
      if ($urandom_range(19) == 0)
        send_request(OP_UNUSED, IDX_IN_W'($urandom), VALUE_W'($urandom));
      if (bi >= nb || (ai < na && $urandom_range(1))) begin
        send_request(OP_LOAD_A, a_list[ai], random_value());
        ai++;
      end else begin
        send_request(OP_LOAD_B, b_list[bi], random_value());
        bi++;
      end
    end
    if ($urandom_range(19) != 0)
      send_request(OP_COMPUTE, IDX_IN_W'($urandom), VALUE_W'($urandom));
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input bit long_hold);
    int start;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    if (long_hold) hold_go <= 1'b1;
    start = requests_sent;
    while (requests_sent - start < PHASE_REQUESTS) run_sequence();
    wait_for_results();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty stores, value extremes, one-sided and mixed walks.
    send_request(OP_COMPUTE, 16'h0000, 24'h000000);
    send_request(OP_LOAD_A, 16'h0000, 24'h7FFFFF);
    send_request(OP_LOAD_B, 16'h0000, 24'h800000);
    send_request(OP_LOAD_A, 16'hFFFF, 24'h800000);
    send_request(OP_LOAD_B, 16'hFFFF, 24'h000000);
    send_request(OP_UNUSED, 16'hFFFF, 24'hFFFFFF);
    send_request(OP_COMPUTE, 16'hFFFF, 24'hFFFFFF);
    send_request(OP_LOAD_A, 16'h0005, 24'h010000);
    send_request(OP_COMPUTE, 16'h0000, 24'h000000);
    send_request(OP_LOAD_B, 16'h8000, 24'hFFFFFF);
    send_request(OP_LOAD_B, 16'h8001, 24'h7FFFFF);
    send_request(OP_COMPUTE, 16'h0000, 24'h000000);
    send_request(OP_LOAD_A, 16'h0001, 24'h123456);
    send_request(OP_LOAD_A, 16'h0004, 24'hFEDCBA);
    send_request(OP_LOAD_B, 16'h0002, 24'h00FFFF);
    send_request(OP_LOAD_B, 16'h0004, 24'h400000);
    send_request(OP_LOAD_B, 16'h0009, 24'hC00000);
    send_request(OP_COMPUTE, 16'h0000, 24'h000000);
    // Unsorted loads still consume each entry once.
    send_request(OP_LOAD_A, 16'h0009, 24'h000100);
    send_request(OP_LOAD_A, 16'h0003, 24'hFFFF00);
    send_request(OP_LOAD_B, 16'h0003, 24'h000200);
    send_request(OP_LOAD_B, 16'h0009, 24'h7F0000);
    send_request(OP_COMPUTE, 16'h0000, 24'h000000);
    wait_for_results();

    // Full stores: drop loads on A, then on B alone, then check the flag clears.
    for (int k = 0; k < DEF_MAX_ENTRIES + 2; k++)
      send_request(OP_LOAD_A, IDX_IN_W'(k * 3), random_value());
    for (int k = 0; k < DEF_MAX_ENTRIES; k++)
      send_request(OP_LOAD_B, IDX_IN_W'(k * 2), random_value());
    send_request(OP_COMPUTE, 16'h0000, 24'h000000);
    for (int k = 0; k < DEF_MAX_ENTRIES + 1; k++)
      send_request(OP_LOAD_B, IDX_IN_W'(65535 - k), random_value());
    send_request(OP_COMPUTE, 16'h0000, 24'h000000);
    send_request(OP_COMPUTE, 16'h0000, 24'h000000);
    wait_for_results();

    // Random traffic under each idling pattern.
    run_phase(0, 0, 1'b0);
    run_phase(52, 0, 1'b0);
    run_phase(0, 52, 1'b1);
    run_phase(9, 9, 1'b0);

    // Keep the output open for a while to catch anything unrequested.
    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Drove %0d requests and checked %0d distances, %0d mismatches.",
             requests_sent, distances_seen, mismatches);
    $display("Covered empty and overflowing stores, unsorted and ignored requests, %s",
             "idle and stalled channels and a long output hold-off.");
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
